// ----- design/sner_pkg.sv -----
package sner_pkg;

  localparam int EMISSION_BITS = 40;
  localparam int TEMP_W        = 17;
  localparam int MOIST_W       = 17;
  localparam int COEF_W        = 16;
  localparam int LIMIT_W       = 15;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int P_W           = 49;
  localparam int EXP_TERMS     = 12;
  localparam int PROD_FRAC     = 70;

  localparam logic [19:0] ZERO_C_Q1280 = 20'd349632;
  localparam logic [31:0] LN2_Q24      = 32'd11629080;
  localparam logic [31:0] LN_UNIT_Q24  = 32'd244572393;
  // exponent bias keeps the offset exponent positive
  localparam int          N_BIAS       = 32;
  localparam logic [31:0] X_OFFSET     = LN_UNIT_Q24 + 32'(N_BIAS) * LN2_Q24;
  // floor(2^32 / ln2 in Q24)
  localparam logic [8:0]  LN2_RECIP    = 9'd369;
  // floor(2^22 / 5)
  localparam logic [19:0] FIVE_RECIP   = 20'd838860;

  localparam logic [CFG_INDEX_W-1:0] REG_BIOME      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CAP   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_COEFF = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MOIST_ONE  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MOIST_TWO  = 3'd4;

  typedef struct packed {
    logic [TEMP_W-1:0]        temperature_kelvin;
    logic [MOIST_W-1:0]       moisture_frac;
    logic [EMISSION_BITS-1:0] prior_emission;
  } item_t;

  typedef struct packed {
    logic [EMISSION_BITS-1:0] total_emission;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    logic                     live;
    logic [P_W-1:0]           p;
    logic [8:0]               q;
    logic [EMISSION_BITS-1:0] prior;
  } side_t;

endpackage

// ----- design/soil_nox_emission_rate.sv -----
// channel   | signals                              | moves
// item      | item_valid, item_ready, item         | one grid cell request
// result    | result_valid, result_ready, result   | emission total and clip flag
// cfg       | cfg_valid, cfg_ready, cfg_index/data | register write, always ready
// one cell enters per cycle while the pipeline advances, through 50 register stages: 10 exponent stages,
// 36 for the 12-term exp series (multiply, reciprocal multiply, correct), 4 to multiply by p, scale and add
// the whole pipeline advances together whenever the output register is empty or taken
// a stall holds every stage, nothing is dropped or repeated
// rst is synchronous: valid bits clear, config registers return to their defaults
module soil_nox_emission_rate (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  sner_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output sner_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sner_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sner_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int EB = sner_pkg::EMISSION_BITS;
  localparam int PW = 80;
  localparam int NT = sner_pkg::EXP_TERMS;
  localparam logic [EB-1:0] MAXE = '1;
  localparam logic [8:0] SH_ZERO = 9'(sner_pkg::PROD_FRAC + sner_pkg::N_BIAS);

  logic adv;
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;
  assign cfg_ready  = 1'b1;

  // registers
  logic [15:0] biome;
  logic [14:0] temp_cap;
  logic [15:0] temp_coeff;
  logic [15:0] moist_one;
  logic [15:0] moist_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      biome      <= 16'd2048;
      temp_cap   <= 15'd7680;
      temp_coeff <= 16'd6750;
      moist_one  <= 16'd22528;
      moist_two  <= 16'(17'h10000 - 17'd22733);
    end else if (cfg_valid) begin
      case (cfg_index)
        sner_pkg::REG_BIOME:      biome      <= cfg_data;
        sner_pkg::REG_TEMP_CAP:   temp_cap   <= cfg_data[14:0];
        sner_pkg::REG_TEMP_COEFF: temp_coeff <= cfg_data;
        sner_pkg::REG_MOIST_ONE:  moist_one  <= cfg_data;
        sner_pkg::REG_MOIST_TWO:  moist_two  <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits of the front stages
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10} <= '0;
    end else if (adv) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
      v10 <= v9;
    end
  end

  // stage 1: celsius, biome*c1, w*w
  logic [19:0]        t5;
  logic signed [19:0] tc5_c;
  logic               neg_c;
  logic [15:0]        c2mag_c;
  assign t5      = 20'(item.temperature_kelvin) * 20'd5;
  assign tc5_c   = $signed(t5 - sner_pkg::ZERO_C_Q1280);
  assign neg_c   = moist_two[15];
  assign c2mag_c = neg_c ? 16'(17'h10000 - 17'(moist_two)) : moist_two;

  logic signed [19:0] tc5_1;
  logic [31:0]        bc1;
  logic [16:0]        w1;
  logic [33:0]        ww1;
  logic [15:0]        c2mag1;
  logic               neg1;
  logic [EB-1:0]      prior1;

  always_ff @(posedge clk) begin
    if (adv) begin
      tc5_1  <= tc5_c;
      bc1    <= 32'(biome) * 32'(moist_one);
      w1     <= item.moisture_frac;
      ww1    <= 34'(item.moisture_frac) * 34'(item.moisture_frac);
      c2mag1 <= c2mag_c;
      neg1   <= neg_c;
      prior1 <= item.prior_emission;
    end
  end

  // stage 2: p, clamp temperature, c2*w*w
  logic [sner_pkg::P_W-1:0] p_c;
  logic [18:0]              tc5u;
  logic [18:0]              lim5;
  assign p_c  = 49'(bc1) * 49'(w1);
  assign tc5u = 19'(tc5_1);
  assign lim5 = 19'(temp_cap) * 19'd5;

  sner_pkg::side_t s2, s3, s4, s5, s6, s7, s8, s9, s10;
  logic [18:0] tcm2;
  logic [49:0] bprod2;
  logic        neg2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.live  <= (tc5_1 > 20'sd0) && (p_c != '0);
      s2.p     <= p_c;
      s2.q     <= '0;
      s2.prior <= prior1;
      tcm2     <= (tc5u < lim5) ? tc5u : lim5;
      bprod2   <= 50'(c2mag1) * 50'(ww1);
      neg2     <= neg1;
    end
  end

  // stage 3: tcm / 5 estimate, round moisture exponent
  logic [38:0] q1prod;
  logic [50:0] bround;
  assign q1prod = 39'(tcm2) * 39'(sner_pkg::FIVE_RECIP);
  assign bround = 51'(bprod2) + 51'(20'h80000);

  logic [15:0] q1r3;
  logic [18:0] tcm3;
  logic [29:0] bmag3;
  logic        neg3;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3    <= s2;
      q1r3  <= q1prod[37:22];
      tcm3  <= tcm2;
      bmag3 <= bround[49:20];
      neg3  <= neg2;
    end
  end

  // stage 4: correct quotient
  logic [18:0] rem1;
  assign rem1 = tcm3 - 19'(q1r3) * 19'd5;

  logic [15:0] q1_4;
  logic [2:0]  r1_4;
  logic [29:0] bmag4;
  logic        neg4;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4 <= s3;
      if (rem1 >= 19'd5) begin
        q1_4 <= q1r3 + 16'd1;
        r1_4 <= 3'(rem1 - 19'd5);
      end else begin
        q1_4 <= q1r3;
        r1_4 <= 3'(rem1);
      end
      bmag4 <= bmag3;
      neg4  <= neg3;
    end
  end

  // stage 5: k*q and k*r + 2
  logic [31:0] kq5;
  logic [17:0] v2_5;
  logic [29:0] bmag5;
  logic        neg5;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5    <= s4;
      kq5   <= 32'(temp_coeff) * 32'(q1_4);
      v2_5  <= 18'(temp_coeff) * 18'(r1_4) + 18'd2;
      bmag5 <= bmag4;
      neg5  <= neg4;
    end
  end

  // stage 6: (k*r + 2) / 5 estimate
  logic [37:0] q2prod;
  assign q2prod = 38'(v2_5) * 38'(sner_pkg::FIVE_RECIP);

  logic [15:0] q2r6;
  logic [17:0] v2_6;
  logic [31:0] kq6;
  logic [29:0] bmag6;
  logic        neg6;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6    <= s5;
      q2r6  <= q2prod[37:22];
      v2_6  <= v2_5;
      kq6   <= kq5;
      bmag6 <= bmag5;
      neg6  <= neg5;
    end
  end

  // stage 7: temperature exponent
  logic [17:0] rem2;
  logic [15:0] q2_c;
  assign rem2 = v2_6 - 18'(q2r6) * 18'd5;
  assign q2_c = (rem2 >= 18'd5) ? q2r6 + 16'd1 : q2r6;

  logic [31:0] a7;
  logic [29:0] bmag7;
  logic        neg7;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7    <= s6;
      a7    <= kq6 + 32'(q2_c);
      bmag7 <= bmag6;
      neg7  <= neg6;
    end
  end

  // stage 8: biased total exponent
  logic [31:0] x8;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8 <= s7;
      x8 <= neg7 ? a7 + sner_pkg::X_OFFSET - 32'(bmag7)
                 : a7 + sner_pkg::X_OFFSET + 32'(bmag7);
    end
  end

  // stage 9: exponent / ln2 estimate
  logic [40:0] nprod;
  assign nprod = 41'(x8) * 41'(sner_pkg::LN2_RECIP);

  logic [8:0]  q9;
  logic [31:0] x9;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9 <= s8;
      q9 <= nprod[40:32];
      x9 <= x8;
    end
  end

  // stage 10: correct into power and remainder
  logic [31:0] xrem;
  assign xrem = x9 - 32'(q9) * sner_pkg::LN2_Q24;

  logic [23:0] r10;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10.live  <= s9.live;
      s10.p     <= s9.p;
      s10.prior <= s9.prior;
      if (xrem >= sner_pkg::LN2_Q24) begin
        s10.q <= q9 + 9'd1;
        r10   <= 24'(xrem - sner_pkg::LN2_Q24);
      end else begin
        s10.q <= q9;
        r10   <= 24'(xrem);
      end
    end
  end

  // exp series, three stages per term
  logic            chain_v    [0:NT];
  sner_pkg::side_t chain_sd   [0:NT];
  logic [30:0]     chain_term [0:NT];
  logic [31:0]     chain_sum  [0:NT];
  logic [29:0]     chain_r30  [0:NT];

  assign chain_v[0]    = v10;
  assign chain_sd[0]   = s10;
  assign chain_term[0] = 31'h4000_0000;
  assign chain_sum[0]  = 32'h4000_0000;
  assign chain_r30[0]  = {r10, 6'd0};

  for (genvar g = 0; g < NT; g++) begin : g_term
    localparam int K = g + 1;
    localparam logic [31:0] MK = 32'((64'd1 << 31) / K);

    logic            av, bv, cv;
    sner_pkg::side_t asd, bsd, csd;
    logic [60:0]     aprod;
    logic [31:0]     asum, bsum, csum;
    logic [29:0]     ar30, br30, cr30;
    logic [30:0]     bval, cterm;
    logic [62:0]     bpm;
    logic [30:0]     cq0, crem, cq;

    assign cq0  = bpm[61:31];
    assign crem = bval - 31'(cq0 * 31'(K));
    assign cq   = (crem >= 31'(K)) ? cq0 + 31'd1 : cq0;

    always_ff @(posedge clk) begin
      if (rst) begin
        av <= 1'b0;
        bv <= 1'b0;
        cv <= 1'b0;
      end else if (adv) begin
        av <= chain_v[g];
        bv <= av;
        cv <= bv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        asd   <= chain_sd[g];
        aprod <= 61'(chain_term[g]) * 61'(chain_r30[g]);
        asum  <= chain_sum[g];
        ar30  <= chain_r30[g];
        bsd   <= asd;
        bval  <= aprod[60:30];
        bpm   <= 63'(aprod[60:30]) * 63'(MK);
        bsum  <= asum;
        br30  <= ar30;
        csd   <= bsd;
        cterm <= cq;
        csum  <= bsum + 32'(cq);
        cr30  <= br30;
      end
    end

    assign chain_v[g+1]    = cv;
    assign chain_sd[g+1]   = csd;
    assign chain_term[g+1] = cterm;
    assign chain_sum[g+1]  = csum;
    assign chain_r30[g+1]  = cr30;
  end

  // product p * mantissa
  logic            vm1, vm2, vsc;
  sner_pkg::side_t sm1, sm2, ssc;
  logic [48:0]     mh1;
  logic [63:0]     ml1;
  logic [PW-1:0]   prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
      vm2 <= 1'b0;
      vsc <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      vm1 <= chain_v[NT];
      vm2 <= vm1;
      vsc <= vm2;
      result_valid <= vsc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm1   <= chain_sd[NT];
      mh1   <= 49'(chain_sd[NT].p[48:32]) * 49'(chain_sum[NT]);
      ml1   <= 64'(chain_sd[NT].p[31:0]) * 64'(chain_sum[NT]);
      sm2   <= sm1;
      prod2 <= 80'(ml1) + (80'(mh1) << 32);
    end
  end

  // scale by the power of two, round, clip
  logic [8:0]    lsh;
  logic [6:0]    rsh1;
  logic [PW-1:0] rsh_val;
  logic [PW:0]   rnd_val;
  logic [EB-1:0] add_c;
  logic          sat_c;

  assign lsh     = sm2.q - SH_ZERO;
  assign rsh1    = 7'(SH_ZERO - 9'd1 - sm2.q);
  assign rsh_val = prod2 >> rsh1;
  assign rnd_val = 81'(rsh_val[PW-1:1]) + 81'(rsh_val[0]);

  always_comb begin
    add_c = '0;
    sat_c = 1'b0;
    if (sm2.live) begin
      if (sm2.q >= SH_ZERO) begin
        if (lsh >= 9'(EB) || (prod2 >> (9'(EB) - lsh)) != '0) begin
          add_c = MAXE;
          sat_c = 1'b1;
        end else begin
          add_c = prod2[EB-1:0] << lsh;
        end
      end else if (rnd_val[PW:EB] != '0) begin
        add_c = MAXE;
        sat_c = 1'b1;
      end else begin
        add_c = rnd_val[EB-1:0];
      end
    end
  end

  logic [EB-1:0] add_sc;
  logic          sat_sc;

  always_ff @(posedge clk) begin
    if (adv) begin
      ssc    <= sm2;
      add_sc <= add_c;
      sat_sc <= sat_c;
    end
  end

  // accumulate with saturation
  always_ff @(posedge clk) begin
    if (adv) begin
      if (add_sc > MAXE - ssc.prior) begin
        result.total_emission <= MAXE;
        result.saturated      <= 1'b1;
      end else begin
        result.total_emission <= ssc.prior + add_sc;
        result.saturated      <= sat_sc;
      end
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    v10 |-> (r10 < 24'(sner_pkg::LN2_Q24)) && (s10.q <= 9'd282))
    else $error("exponent split out of range");

  a_mant_range: assert property (@(posedge clk) disable iff (rst)
    chain_v[NT] && chain_sd[NT].live |->
      (chain_sum[NT] >= 32'h4000_0000) && (chain_sum[NT] < 32'h8000_0000))
    else $error("mantissa outside [1, 2)");

  a_cold_zero: assert property (@(posedge clk) disable iff (rst)
    vsc && !ssc.live |-> (add_sc == '0) && !sat_sc)
    else $error("cold or empty cell produced a term");

endmodule

// ----- bench/emission_checker.sv -----
module emission_checker
  import sner_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_ready,
  input  item_t                  item,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  result_t                result,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned EMIS_MAX = (64'd1 << EMISSION_BITS) - 1;

  logic [COEF_W-1:0]  biome;
  logic [LIMIT_W-1:0] temp_cap;
  logic [COEF_W-1:0]  temp_coeff;
  logic [COEF_W-1:0]  moist_one;
  logic [COEF_W-1:0]  moist_two;

  result_t expected_totals[$];

  function automatic longint unsigned exp_series(longint unsigned r24);
    longint unsigned r30, term, sum;
    r30 = r24 << 6;
    term = 64'd1 << 30;
    sum = term;
    for (int k = 1; k <= EXP_TERMS; k++) begin
      term = ((term * r30) >> 30) / k;
      sum += term;
    end
    return sum;
  endfunction

  function automatic result_t predict_emission(item_t c);
    longint unsigned t, w, prior, p, lim5, tcm, a, c2mag, bmag, m, add;
    longint tc5, x, n, r, e;
    logic [191:0] prod, scaled;
    bit neg, sat;
    int s;
    result_t o;
    t = c.temperature_kelvin;
    w = c.moisture_frac;
    prior = c.prior_emission;
    tc5 = longint'(t * 5) - longint'(ZERO_C_Q1280);
    p = longint'(biome) * longint'(moist_one) * w;
    add = 0;
    sat = 0;
    if (tc5 > 0 && p != 0) begin
      lim5 = longint'(temp_cap) * 5;
      tcm = (longint'(tc5) < lim5) ? longint'(tc5) : lim5;
      a = (longint'(temp_coeff) * tcm + 2) / 5;
      neg = moist_two[15];
      c2mag = neg ? (65536 - longint'(moist_two)) : longint'(moist_two);
      bmag = (c2mag * (w * w) + (64'd1 << 19)) >> 20;
      x = longint'(a) + longint'(LN_UNIT_Q24) + (neg ? -longint'(bmag) : longint'(bmag));
      if (x >= 0) n = x / longint'(LN2_Q24);
      else n = -((-x + longint'(LN2_Q24) - 1) / longint'(LN2_Q24));
      r = x - n * longint'(LN2_Q24);
      m = exp_series(r);
      prod = 192'(p) * 192'(m);
      e = n - PROD_FRAC;
      if (e >= 0) begin
        if (e >= 64) begin
          sat = 1;
          add = EMIS_MAX;
        end else begin
          scaled = prod << e;
          if (scaled > EMIS_MAX) begin
            sat = 1;
            add = EMIS_MAX;
          end else add = 64'(scaled);
        end
      end else begin
        s = -e;
        if (s <= 100) begin
          scaled = (prod >> s) + prod[s-1];
          if (scaled > EMIS_MAX) begin
            sat = 1;
            add = EMIS_MAX;
          end else add = 64'(scaled);
        end
      end
    end
    if (add > EMIS_MAX - prior) begin
      o.total_emission = EMIS_MAX;
      sat = 1;
    end else o.total_emission = 40'(prior + add);
    o.saturated = sat;
    return o;
  endfunction

  assign pending = expected_totals.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      biome <= 16'd2048;
      temp_cap <= 15'd7680;
      temp_coeff <= 16'd6750;
      moist_one <= 16'd22528;
      moist_two <= 16'(-22733);
      fail_count <= 0;
      expected_totals.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BIOME: biome <= cfg_data;
          REG_TEMP_CAP: temp_cap <= cfg_data[LIMIT_W-1:0];
          REG_TEMP_COEFF: temp_coeff <= cfg_data;
          REG_MOIST_ONE: moist_one <= cfg_data;
          REG_MOIST_TWO: moist_two <= cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready) expected_totals.push_back(predict_emission(item));
      if (result_valid && result_ready) begin
        if (expected_totals.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", result);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_totals.pop_front();
          if (want.total_emission !== result.total_emission ||
              want.saturated !== result.saturated) begin
            if (fail_count < 10)
              $display("mismatch: expected total %h sat %b, got total %h sat %b",
                       want.total_emission, want.saturated,
                       result.total_emission, result.saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- bench/tb.sv -----
module tb;
  import sner_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned EMIS_MAX = (64'd1 << EMISSION_BITS) - 1;
  localparam int LIMIT_CYCLES = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 0;
  result_t result;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count;
  int pending;
  bit calm = 0;
  int cycles = 0;

  soil_nox_emission_rate u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  emission_checker u_check (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: one long hold-off early on, then random bursts of back-pressure
  initial begin
    @(negedge rst);
    @(posedge clk);
    result_ready <= 1;
    repeat (300) @(posedge clk);
    result_ready <= 0;
    repeat (400) @(posedge clk);
    result_ready <= 1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        result_ready <= 0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        result_ready <= 1;
      end
    end
  end

  task automatic send_cell(item_t c);
    item <= c;
    item_valid <= 1;
    do @(posedge clk); while (!item_ready);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic item_t random_cell();
    item_t c;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) c.temperature_kelvin = 17'($urandom_range(0, 69926));
    else if (mode < 3) c.temperature_kelvin = 17'($urandom_range(69920, 69940));
    else c.temperature_kelvin = 17'($urandom_range(69927, 102399));
    mode = $urandom_range(0, 15);
    if (mode == 0) c.moisture_frac = 17'd65536;
    else if (mode == 1) c.moisture_frac = 0;
    else if (mode == 2) c.moisture_frac = 17'($urandom_range(65537, 131071));
    else c.moisture_frac = 17'($urandom_range(0, 65535));
    mode = $urandom_range(0, 3);
    if (mode == 0) c.prior_emission = 40'({$urandom, $urandom});
    else if (mode == 1) c.prior_emission = 40'(EMIS_MAX - $urandom_range(0, 1000000));
    else if (mode == 2) c.prior_emission = 40'($urandom_range(0, 65535));
    else c.prior_emission = 40'({$urandom, $urandom} >> $urandom_range(0, 39));
    return c;
  endfunction

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    item_t c;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed cells at reset settings
    send_cell('{17'd0, 17'd0, 40'd0});
    send_cell('{17'd102399, 17'd65536, EMIS_MAX[39:0]});
    send_cell('{17'd102399, 17'd65536, 40'd0});
    send_cell('{17'd69926, 17'd32768, 40'd5});
    send_cell('{17'd69927, 17'd32768, 40'd5});
    send_cell('{17'd80000, 17'd0, 40'd77});
    send_cell('{17'd80000, 17'd65535, 40'd0});
    send_cell('{17'd80000, 17'd1, 40'd0});
    send_cell('{17'd90000, 17'd30000, EMIS_MAX[39:0]});
    send_cell('{17'd90000, 17'd30000, EMIS_MAX[39:0] - 40'd1});
    send_cell('{17'd65536, 17'd20000, 40'h5555555555});
    send_cell('{17'd101000, 17'd10000, 40'hAAAAAAAAAA});

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        item_valid <= 0;
        drain();
        case (ph)
          1: begin
            write_reg(REG_BIOME, 16'hFFFF);
            write_reg(REG_TEMP_CAP, 16'hFFFF);
            write_reg(REG_TEMP_COEFF, 16'hFFFF);
            write_reg(REG_MOIST_ONE, 16'hFFFF);
            write_reg(REG_MOIST_TWO, 16'h7FFF);
          end
          2: begin
            write_reg(REG_BIOME, 16'h0001);
            write_reg(REG_TEMP_CAP, 16'd0);
            write_reg(REG_TEMP_COEFF, 16'd0);
            write_reg(REG_MOIST_ONE, 16'h0001);
            write_reg(REG_MOIST_TWO, 16'h8000);
          end
          3: begin
            write_reg(REG_BIOME, 16'd0);
            write_reg(REG_TEMP_CAP, 16'd25600);
            write_reg(REG_MOIST_TWO, 16'd0);
          end
          6: begin
            write_reg(REG_BIOME, 16'd2048);
            write_reg(REG_TEMP_CAP, 16'd7680);
            write_reg(REG_TEMP_COEFF, 16'd6750);
            write_reg(REG_MOIST_ONE, 16'd22528);
            write_reg(REG_MOIST_TWO, 16'(-22733));
            calm = 1;
          end
          default: begin
            write_reg(REG_BIOME, 16'($urandom));
            write_reg(REG_TEMP_CAP, 16'($urandom_range(0, 25600)));
            write_reg(REG_TEMP_COEFF, 16'($urandom));
            write_reg(REG_MOIST_ONE, 16'($urandom));
            write_reg(REG_MOIST_TWO, 16'($urandom));
          end
        endcase
        // out-of-range index, must be ignored
        write_reg(3'($urandom_range(5, 7)), 16'($urandom));
        cfg_valid <= 0;
        @(posedge clk);
      end
      for (int i = 0; i < 270; i++) begin
        c = random_cell();
        send_cell(c);
      end
    end
    item_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/sner_pkg.sv
design/soil_nox_emission_rate.sv
bench/emission_checker.sv
bench/tb.sv
